[rtl/set_assoc_lru_writeback_cache_tags_top_defines.svh]
// assertion macros for the cache tag array
// clocked on clk_i, disabled while rst_ni is low; used by set_assoc_lru_writeback_cache_tags_top
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_TAGS_TOP_DEFINES_SVH

// condition that holds at every edge
`define SALRU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define SALRU_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

[rtl/salru_pkg.sv]
// shared types and constants of the set-associative lru cache tag array
// no dependencies; used by set_assoc_lru_writeback_cache_tags_top
`timescale 1ns / 1ps

package salru_pkg;

  localparam int unsigned MAX_WAYS_DEF = 8;
  localparam int unsigned MAX_SETS_DEF = 64;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned AGE_W      = 32;
  localparam int unsigned OFFSET_W   = 5;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned WAYS_W     = 4;
  localparam int unsigned WAY_OUT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  localparam int unsigned OFFSET_MAX = 16;

  localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd3;
  localparam logic [INDEX_W-1:0]  INDEX_RST  = 3'd4;
  localparam logic [WAYS_W-1:0]   WAYS_RST   = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

endpackage

[rtl/set_assoc_lru_writeback_cache_tags_top.sv]
// Tag and state array of a set-associative write-back cache with lru replacement.
// Inputs: a write port for offset_bits, index_bits and ways_in_use, and a
// valid/stall transaction channel carrying kind and address. Outputs: one
// result transaction (hit, writeback, way_used) per access, in order.
// An access reads its whole set row from a synchronous memory with a registered
// read, then updates and writes the row back. Hits and fills go through lookup
// and write-back; a replacement also walks the oldest-age compare tree level by
// level, log2(MAX_WAYS) levels, before its write-back. The next access is taken in
// the write-back cycle; if it hits the same set the written row is forwarded.
// The result is registered at the end of the write-back cycle.
// Reset clears the configuration to 3/4/8, the access clock and a per-set
// valid flag; a set never written reads as all zero, so no clearing pass runs.
// A stalled result holds in the output register; the access behind it waits
// in its write-back cycle and no new transaction is taken until it moves.
// Depends on salru_pkg and set_assoc_lru_writeback_cache_tags_top_defines.svh.
`timescale 1ns / 1ps
`include "set_assoc_lru_writeback_cache_tags_top_defines.svh"

module set_assoc_lru_writeback_cache_tags_top #(
  parameter int unsigned MAX_WAYS = salru_pkg::MAX_WAYS_DEF,
  parameter int unsigned MAX_SETS = salru_pkg::MAX_SETS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic [salru_pkg::ADDR_W-1:0]        address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic                                writeback_o,
  output logic [salru_pkg::WAY_OUT_W-1:0]     way_used_o
);

  localparam int unsigned WAY_IW   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned LOG_SETS = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned IB_W     = $clog2(LOG_SETS + 1) + 3;
  localparam int unsigned NWAYS_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned LVLS     = $clog2(MAX_WAYS);
  localparam int unsigned NPOW     = 1 << LVLS;
  localparam int unsigned LVL_W    = (LVLS > 0) ? $clog2(LVLS + 1) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_REDUCE,
    ST_FINISH
  } state_e;

  typedef salru_pkg::line_t [MAX_WAYS-1:0] row_t;

  // configuration
  logic [salru_pkg::OFFSET_W-1:0] cfg_off_q;
  logic [salru_pkg::INDEX_W-1:0]  cfg_idx_q;
  logic [salru_pkg::WAYS_W-1:0]   cfg_ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_off_q  <= salru_pkg::OFFSET_RST;
      cfg_idx_q  <= salru_pkg::INDEX_RST;
      cfg_ways_q <= salru_pkg::WAYS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        salru_pkg::CFG_OFFSET_BITS: cfg_off_q  <= cfg_wdata_i[salru_pkg::OFFSET_W-1:0];
        salru_pkg::CFG_INDEX_BITS:  cfg_idx_q  <= cfg_wdata_i[salru_pkg::INDEX_W-1:0];
        salru_pkg::CFG_WAYS_IN_USE: cfg_ways_q <= cfg_wdata_i[salru_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [salru_pkg::OFFSET_W-1:0] ob;
  logic [IB_W-1:0]                ib;
  logic [NWAYS_W-1:0]             nways;
  logic [salru_pkg::ADDR_W-1:0]   set_full;
  logic [SET_W-1:0]               rd_set;
  logic [salru_pkg::TAG_W-1:0]    rd_tag;

  always_comb begin
    ob = (32'(cfg_off_q) > salru_pkg::OFFSET_MAX) ?
         salru_pkg::OFFSET_W'(salru_pkg::OFFSET_MAX) : cfg_off_q;
    ib = (32'(cfg_idx_q) > LOG_SETS) ? IB_W'(LOG_SETS) : IB_W'(cfg_idx_q);
    if (cfg_ways_q == '0) begin
      nways = NWAYS_W'(1);
    end else if (32'(cfg_ways_q) > MAX_WAYS) begin
      nways = NWAYS_W'(MAX_WAYS);
    end else begin
      nways = NWAYS_W'(cfg_ways_q);
    end
    set_full = (address_i >> ob) & ((32'd1 << ib) - 32'd1);
    rd_set   = set_full[SET_W-1:0];
    rd_tag   = address_i >> (6'(ob) + 6'(ib));
  end

  // control
  state_e                       state_q, state_d;
  logic [LVL_W-1:0]             lvl_q, lvl_d;
  logic                         out_valid_q, out_valid_d;
  logic                         hit_q, hit_d;
  logic                         wb_q, wb_d;
  logic [salru_pkg::WAY_OUT_W-1:0] way_q, way_d;
  logic [salru_pkg::AGE_W-1:0]  stamp_q, stamp_d;
  logic                         out_free, fin_go, acc, wr_en;

  // captured access
  logic                         kind_q;
  logic [salru_pkg::TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]             set_q;

  // set memory with per-set reset flags
  row_t                         mem_q [MAX_SETS];
  row_t                         mem_rd_q;
  row_t                         fwd_row_q;
  logic                         fwd_q, rv_q;
  logic [MAX_SETS-1:0]          row_vld_q;
  row_t                         eff_row, wr_row;

  // lookup and replacement search
  logic                         found_q, found_d;
  logic                         found_hit_q, found_hit_d;
  logic [WAY_IW-1:0]            found_idx_q, found_idx_d;
  logic [salru_pkg::AGE_W-1:0]  cand_age_q [NPOW];
  logic [salru_pkg::AGE_W-1:0]  cand_age_d [NPOW];
  logic [WAY_IW-1:0]            cand_idx_q [NPOW];
  logic [WAY_IW-1:0]            cand_idx_d [NPOW];
  logic [NPOW-1:0]              cand_ok_q, cand_ok_d;

  logic [WAY_IW-1:0]            way_sel;
  logic [31:0]                  way_ext;
  salru_pkg::line_t             old_line, new_line;
  logic                         hit_n;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_go     = (state_q == ST_FINISH) && out_free;
  assign in_stall_o = !((state_q == ST_IDLE) || fin_go);
  assign acc        = in_valid_i && !in_stall_o;
  assign wr_en      = fin_go;

  assign eff_row = fwd_q ? fwd_row_q : (rv_q ? mem_rd_q : '0);

  // tag compare over the scanned ways, the lowest way that hits or is free wins
  always_comb begin
    found_d     = 1'b0;
    found_hit_d = 1'b0;
    found_idx_d = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (32'(w) < 32'(nways) && (!eff_row[w].valid || eff_row[w].tag == tag_q)) begin
        found_d     = 1'b1;
        found_hit_d = eff_row[w].valid;
        found_idx_d = WAY_IW'(w);
      end
    end
  end

  // oldest-age tree, one level per cycle, left wins ties
  always_comb begin
    cand_ok_d = '0;
    for (int k = 0; k < NPOW; k++) begin
      cand_age_d[k] = '0;
      cand_idx_d[k] = '0;
    end
    if (state_q == ST_LOOK) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        cand_age_d[w] = eff_row[w].age;
        cand_idx_d[w] = WAY_IW'(w);
        cand_ok_d[w]  = 32'(w) < 32'(nways);
      end
    end else begin
      for (int k = 0; k < NPOW / 2; k++) begin
        if (!cand_ok_q[2*k] ||
            (cand_ok_q[2*k+1] && cand_age_q[2*k+1] < cand_age_q[2*k])) begin
          cand_age_d[k] = cand_age_q[2*k+1];
          cand_idx_d[k] = cand_idx_q[2*k+1];
          cand_ok_d[k]  = cand_ok_q[2*k+1];
        end else begin
          cand_age_d[k] = cand_age_q[2*k];
          cand_idx_d[k] = cand_idx_q[2*k];
          cand_ok_d[k]  = cand_ok_q[2*k];
        end
      end
    end
  end

  // row update for the write-back cycle
  always_comb begin
    way_sel  = found_q ? found_idx_q : cand_idx_q[0];
    way_ext  = 32'(way_sel);
    old_line = eff_row[way_sel];
    hit_n    = found_q && found_hit_q;
    new_line.valid = 1'b1;
    new_line.age   = stamp_q;
    if (hit_n) begin
      new_line.dirty = old_line.dirty | kind_q;
      new_line.tag   = old_line.tag;
    end else begin
      new_line.dirty = kind_q;
      new_line.tag   = tag_q;
    end
    wr_row          = eff_row;
    wr_row[way_sel] = new_line;
  end

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q && out_stall_i;
    hit_d       = hit_q;
    wb_d        = wb_q;
    way_d       = way_q;
    stamp_d     = stamp_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        lvl_d = '0;
        if (found_d || LVLS == 0) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        lvl_d = lvl_q + LVL_W'(1);
        if (lvl_q == LVL_W'(LVLS - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          hit_d       = hit_n;
          wb_d        = !found_q && old_line.dirty;
          way_d       = way_ext[salru_pkg::WAY_OUT_W-1:0];
          stamp_d     = stamp_q + salru_pkg::AGE_W'(1);
          state_d     = acc ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      wb_q        <= 1'b0;
      way_q       <= '0;
      stamp_q     <= '0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      wb_q        <= wb_d;
      way_q       <= way_d;
      stamp_q     <= stamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      fwd_q     <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_q[set_q] <= 1'b1;
      end
      if (acc) begin
        fwd_q <= wr_en && (rd_set == set_q);
        rv_q  <= row_vld_q[rd_set];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[set_q] <= wr_row;
    end
    if (acc) begin
      mem_rd_q  <= mem_q[rd_set];
      fwd_row_q <= wr_row;
      kind_q    <= kind_i;
      tag_q     <= rd_tag;
      set_q     <= rd_set;
    end
    if (state_q == ST_LOOK) begin
      found_q     <= found_d;
      found_hit_q <= found_hit_d;
      found_idx_q <= found_idx_d;
    end
    if (state_q == ST_LOOK || state_q == ST_REDUCE) begin
      cand_age_q <= cand_age_d;
      cand_idx_q <= cand_idx_d;
      cand_ok_q  <= cand_ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign writeback_o = wb_q;
  assign way_used_o  = way_q;

  `SALRU_ASSERT_NEXT(a_acc_to_look, acc, state_q == ST_LOOK, "accepted access did not start lookup")
  `SALRU_ASSERT(a_lvl_bound, state_q != ST_REDUCE || 32'(lvl_q) < LVLS, "compare tree overran")
  `SALRU_ASSERT_NEXT(a_stamp_step, fin_go, stamp_q == $past(stamp_q) + 32'd1, "access clock skipped")
  `SALRU_ASSERT(a_hit_no_wb, !out_valid_o || !(hit_o && writeback_o), "writeback on a hit")
  `SALRU_ASSERT(a_victim_ok, state_q != ST_FINISH || found_q || cand_ok_q[0], "victim outside ways")

endmodule
